/* src/shacal2_block_encrypt_top_defines.svh */
// Assertion helpers for the encrypt block; both sample on clk and are off during reset.
`ifndef SHACAL2_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define SHACAL2_BLOCK_ENCRYPT_TOP_DEFINES_SVH

// Same-cycle implication.
`define SHACAL2_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHACAL2_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/shacal2_pkg.sv */
package shacal2_pkg;

	localparam int WORD_W    = 32;
	localparam int BLK_W     = 8 * WORD_W;
	localparam int KEY_DEPTH = 64;
	localparam int KEY_AW    = $clog2(KEY_DEPTH);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_ENC  = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
		word_t f;
		word_t g;
		word_t h;
	} st_t;

endpackage

/* src/shacal2_ram.sv */
module shacal2_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/shacal2_round.sv */
module shacal2_round (
	input  shacal2_pkg::st_t   st,
	input  shacal2_pkg::word_t key,
	output shacal2_pkg::st_t   nxt
);

	function automatic shacal2_pkg::word_t rotr(input shacal2_pkg::word_t x, input int n);
		return (x >> n) | (x << (shacal2_pkg::WORD_W - n));
	endfunction

	shacal2_pkg::word_t sig0;
	shacal2_pkg::word_t sig1;
	shacal2_pkg::word_t ch;
	shacal2_pkg::word_t maj;
	shacal2_pkg::word_t t1;
	shacal2_pkg::word_t t2;

	always_comb begin
		sig1 = rotr(st.e, 6) ^ rotr(st.e, 11) ^ rotr(st.e, 25);
		ch   = (st.e & st.f) ^ (~st.e & st.g);
		t1   = st.h + sig1 + ch + key;
		sig0 = rotr(st.a, 2) ^ rotr(st.a, 13) ^ rotr(st.a, 22);
		maj  = (st.a & st.b) ^ (st.a & st.c) ^ (st.b & st.c);
		t2   = sig0 + maj;

		nxt.h = st.g;
		nxt.g = st.f;
		nxt.f = st.e;
		nxt.e = st.d + t1;
		nxt.d = st.c;
		nxt.c = st.b;
		nxt.b = st.a;
		nxt.a = t1 + t2;
	end

endmodule

/* src/shacal2_block_encrypt_top.sv */
// SHACAL-2 encryption of one 256-bit block (words A..H, big-endian, A in the top of
// block_word0). A func 0 item writes key_word into round key slot key_index and gives
// no result; key words carry the round constant already. A func 1 item runs
// ROUND_COUNT SHA-256 rounds without feed-forward, one round per cycle through a single
// round unit that reads one key word per cycle from a 64-entry key RAM, then optionally
// XORs the mask in. in_stall stays high while the rounds run; the next item is taken
// only once the result is loaded into the output register. If the previous result
// still waits in the output register when the rounds finish, in_stall stays high until
// that result is taken. Key loads can be taken while a result waits in the output
// register. Key slots must be written before they are used: the key RAM has no reset
// and an unwritten slot reads an arbitrary value.
`include "shacal2_block_encrypt_top_defines.svh"

module shacal2_block_encrypt_top #(
	parameter int ROUND_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [5:0]  key_index,
	input  logic [31:0] key_word,
	input  logic [63:0] block_word0,
	input  logic [63:0] block_word1,
	input  logic [63:0] block_word2,
	input  logic [63:0] block_word3,
	input  logic        use_xor,
	input  logic [63:0] mask_word0,
	input  logic [63:0] mask_word1,
	input  logic [63:0] mask_word2,
	input  logic [63:0] mask_word3,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_word0,
	output logic [63:0] out_word1,
	output logic [63:0] out_word2,
	output logic [63:0] out_word3
);

	localparam int RND_W = $clog2(ROUND_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} fsm_t;

	fsm_t                                 state_q;
	logic [RND_W-1:0]                     rnd_q;
	shacal2_pkg::st_t                     st_q;
	logic [shacal2_pkg::BLK_W-1:0]        mask_q;
	logic [shacal2_pkg::BLK_W-1:0]        out_q;
	logic                                 out_valid_q;

	logic                                 in_accept;
	logic                                 key_we;
	logic                                 last_rnd;
	logic                                 out_free;
	logic                                 out_load;
	logic [shacal2_pkg::KEY_AW-1:0]       rd_addr;
	shacal2_pkg::word_t                   rnd_key;
	shacal2_pkg::st_t                     rnd_st;
	logic [shacal2_pkg::BLK_W-1:0]        fin_blk;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign key_we    = in_accept && (func == shacal2_pkg::FUNC_LOAD);
	assign last_rnd  = (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (((state_q == ST_RUN) && last_rnd) || (state_q == ST_DONE));

	// Prefetch the key of the next round; slot 0 is fetched while idle or done.
	always_comb begin
		if (state_q == ST_RUN) begin
			rd_addr = shacal2_pkg::KEY_AW'(rnd_q) + shacal2_pkg::KEY_AW'(1);
		end else begin
			rd_addr = '0;
		end
	end

	always_comb begin
		if (state_q == ST_RUN) begin
			fin_blk = rnd_st ^ mask_q;
		end else begin
			fin_blk = st_q ^ mask_q;
		end
	end

	shacal2_ram #(
		.WIDTH(shacal2_pkg::WORD_W),
		.DEPTH(shacal2_pkg::KEY_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_index),
		.wdata(key_word),
		.raddr(rd_addr),
		.rdata(rnd_key)
	);

	shacal2_round u_round (
		.st (st_q),
		.key(rnd_key),
		.nxt(rnd_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
			st_q        <= '0;
			mask_q      <= '0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (func == shacal2_pkg::FUNC_ENC)) begin
						st_q    <= {block_word0, block_word1, block_word2, block_word3};
						mask_q  <= use_xor ? {mask_word0, mask_word1, mask_word2, mask_word3}
							: '0;
						rnd_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					st_q  <= rnd_st;
					rnd_q <= rnd_q + RND_W'(1);
					if (last_rnd) begin
						if (out_free) begin
							out_q       <= fin_blk;
							out_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					// hold the ciphertext until the output register frees up
					if (out_free) begin
						out_q       <= fin_blk;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word0 = out_q[255:192];
	assign out_word1 = out_q[191:128];
	assign out_word2 = out_q[127:64];
	assign out_word3 = out_q[63:0];

	`SHACAL2_ASSERT_NXT(a_enc_starts, in_accept && (func == shacal2_pkg::FUNC_ENC), (state_q == ST_RUN) && (rnd_q == '0), "encryption did not start at round zero")
	`SHACAL2_ASSERT_IMP(a_rnd_range, state_q == ST_RUN, rnd_q <= RND_W'(ROUND_COUNT - 1), "round counter ran past the last round")
	`SHACAL2_ASSERT_IMP(a_done_blocked, state_q == ST_DONE, out_valid_q, "waiting on a free output register that is free")
	`SHACAL2_ASSERT_IMP(a_out_source, $rose(out_valid_q), $past(state_q == ST_RUN) || $past(state_q == ST_DONE), "result appeared without a finished encryption")

endmodule
